FILE: rtl/snrs_pkg.sv
// Shared constants, types and codes for the safeguarded Newton root search.
`timescale 1ns / 1ps

package snrs_pkg;

    localparam int VALUE_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int TOL_W     = 31;
    localparam int ITER_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = 6;
    localparam int LANES     = 3;
    localparam int MUL_STEPS = VALUE_W + 1;
    localparam int DIV_STEPS = VALUE_W + FRAC_W;
    localparam int PROD_W    = 2 * VALUE_W + 1;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [VALUE_W:0]   wide_t;
    typedef logic [VALUE_W-1:0]        umag_t;
    typedef logic [PROD_W-1:0]         prod_t;
    typedef logic signed [1:0]         sgn_t;

    localparam value_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam value_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam sgn_t SGN_POS  = 2'sb01;
    localparam sgn_t SGN_NEG  = 2'sb11;
    localparam sgn_t SGN_ZERO = 2'sb00;

    typedef enum logic {
        OP_START = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_EVAL = 2'd0,
        KIND_ROOT = 2'd1,
        KIND_FAIL = 2'd2
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 1'b1;

endpackage

FILE: rtl/snrs_chan_if.sv
// Request and result channel interfaces of the root search block.
`timescale 1ns / 1ps

interface snrs_req_if;
    import snrs_pkg::*;

    logic        valid;
    logic        ready;
    op_t         opcode;
    value_t      bracket_first;
    value_t      bracket_second;
    value_t      f_value;
    value_t      df_value;
    logic        eval_ok;

    modport source (output valid, opcode, bracket_first, bracket_second, f_value,
                    df_value, eval_ok, input ready);
    modport sink   (input valid, opcode, bracket_first, bracket_second, f_value,
                    df_value, eval_ok, output ready);
endinterface

interface snrs_rsp_if;
    import snrs_pkg::*;

    logic        valid;
    logic        ready;
    kind_t       result_kind;
    value_t      point;

    modport source (output valid, result_kind, point, input ready);
    modport sink   (input valid, result_kind, point, output ready);
endinterface

FILE: rtl/safeguarded_newton_root_search_top.sv
// Safeguarded Newton root search sequencer with bit-serial multiply and divide.
`timescale 1ns / 1ps

// Drives an outside evaluator: each result is either a point to evaluate, a root or a failure.
// A start request, an end-point evaluation or the midpoint setup gives its result in the cycle
// after the request is taken. A request that triggers a Newton or bisection step passes
// through a load state, the run state of the one-bit-per-cycle restoring divider (the three
// magnitude products are formed alongside it, one multiplier bit per cycle), a decide state
// and a step state, which registers its result. A new request is taken only while no step
// is in progress and the result register is free or being emptied. Values are Q16.16.
module safeguarded_newton_root_search_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [snrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [snrs_pkg::TOL_W-1:0]          cfg_data,
    snrs_req_if.sink                            req,
    snrs_rsp_if.source                          rsp
);
    import snrs_pkg::*;

    typedef enum logic [4:0] {
        P_IDLE   = 5'b00001,
        P_FIRST  = 5'b00010,
        P_SECOND = 5'b00100,
        P_MID    = 5'b01000,
        P_ITER   = 5'b10000
    } phase_t;

    typedef enum logic [4:0] {
        C_WAIT   = 5'b00001,
        C_LOAD   = 5'b00010,
        C_RUN    = 5'b00100,
        C_DECIDE = 5'b01000,
        C_STEP   = 5'b10000
    } ctl_t;

    function automatic umag_t mag32(input value_t v);
        return v[VALUE_W-1] ? umag_t'(~v + 1'b1) : umag_t'(v);
    endfunction

    function automatic logic [VALUE_W:0] mag33(input wide_t v);
        return v[VALUE_W] ? (~v + 1'b1) : v;
    endfunction

    function automatic value_t sat33(input wide_t s);
        if (s[VALUE_W] != s[VALUE_W-1])
            return s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
        return s[VALUE_W-1:0];
    endfunction

    // halve, truncating toward zero
    function automatic value_t half33(input wide_t s);
        wide_t t;
        t = s + wide_t'({{VALUE_W{1'b0}}, s[VALUE_W]});
        return t[VALUE_W:1];
    endfunction

    function automatic sgn_t sign32(input value_t v);
        if (v == '0)
            return SGN_ZERO;
        return v[VALUE_W-1] ? SGN_NEG : SGN_POS;
    endfunction

    // sign of d*df - f*2^FRAC_W from signs and magnitudes
    function automatic sgn_t term_sgn(input sgn_t sa, input sgn_t sb,
                                      input prod_t ma, input prod_t mb);
        if (sa != sb)
            return (sa > sb) ? SGN_POS : SGN_NEG;
        if (sa == SGN_ZERO || ma == mb)
            return SGN_ZERO;
        if (ma > mb)
            return sa;
        return (sa == SGN_POS) ? SGN_NEG : SGN_POS;
    endfunction

    logic [TOL_W-1:0]   tol_reg;
    logic [ITER_W-1:0]  max_iter_reg;

    phase_t             phase_reg, phase_next;
    ctl_t               ctl_reg, ctl_next;
    value_t             end_first_reg, end_first_next;
    value_t             end_second_reg, end_second_next;
    value_t             vfirst_reg, vfirst_next;
    value_t             low_reg, low_next;
    value_t             high_reg, high_next;
    value_t             cur_reg, cur_next;
    umag_t              last_reg, last_next;
    umag_t              prev_reg, prev_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    value_t             f_reg, f_next;
    value_t             df_reg, df_next;

    umag_t              acc_reg [LANES];
    umag_t              acc_next [LANES];
    logic [VALUE_W:0]   mpl_reg [LANES];
    logic [VALUE_W:0]   mpl_next [LANES];
    umag_t              mcand_reg, mcand_next;
    umag_t              rem_reg, rem_next;
    logic [DIV_STEPS-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               bisect_reg, bisect_next;
    value_t             half_reg, half_next;
    value_t             q_reg, q_next;

    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg, out_kind_next;
    value_t             out_point_reg, out_point_next;

    logic               in_fire;
    logic               out_free;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (ctl_reg == C_WAIT) && out_free;
    assign in_fire   = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_kind = out_kind_reg;
    assign rsp.point       = out_point_reg;

    always_comb
    begin
        wide_t              sum_w;
        wide_t              dh;
        wide_t              dl;
        logic [VALUE_W:0]   msum;
        logic [VALUE_W:0]   shifted;
        logic               qbit;
        umag_t              fmag;
        prod_t              mb;
        prod_t              lhs;
        sgn_t               sf;
        sgn_t               sdf;
        sgn_t               sa;
        sgn_t               sb;
        sgn_t               ta;
        sgn_t               tb;
        logic [DIV_STEPS-1:0] qm;
        value_t             nxt;
        umag_t              step_mag;
        logic               root_hit;
        logic [ITER_W-1:0]  iter_up;

        phase_next      = phase_reg;
        ctl_next        = ctl_reg;
        end_first_next  = end_first_reg;
        end_second_next = end_second_reg;
        vfirst_next     = vfirst_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        prev_next       = prev_reg;
        iter_next       = iter_reg;
        f_next          = f_reg;
        df_next         = df_reg;
        acc_next        = acc_reg;
        mpl_next        = mpl_reg;
        mcand_next      = mcand_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        cnt_next        = cnt_reg;
        bisect_next     = bisect_reg;
        half_next       = half_reg;
        q_next          = q_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_kind_next   = out_kind_reg;
        out_point_next  = out_point_reg;

        sum_w    = '0;
        dh       = wide_t'(cur_reg) - wide_t'(high_reg);
        dl       = wide_t'(cur_reg) - wide_t'(low_reg);
        msum     = '0;
        shifted  = '0;
        qbit     = 1'b0;
        fmag     = mag32(f_reg);
        mb       = prod_t'({fmag, {FRAC_W{1'b0}}});
        lhs      = prod_t'({fmag, {(FRAC_W+1){1'b0}}});
        sf       = sign32(f_reg);
        sdf      = sign32(df_reg);
        sa       = SGN_ZERO;
        sb       = SGN_ZERO;
        ta       = SGN_ZERO;
        tb       = SGN_ZERO;
        qm       = dvd_reg;
        nxt      = '0;
        step_mag = '0;
        root_hit = 1'b0;
        iter_up  = iter_reg + 1'b1;

        unique case (ctl_reg)
            C_WAIT:
            begin
                if (in_fire)
                begin
                    if (req.opcode == OP_START)
                    begin
                        end_first_next  = req.bracket_first;
                        end_second_next = req.bracket_second;
                        iter_next       = '0;
                        phase_next      = P_FIRST;
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_EVAL;
                        out_point_next  = req.bracket_first;
                    end
                    else if (phase_reg == P_IDLE)
                    begin
                        phase_next = P_IDLE;
                    end
                    else if (!req.eval_ok)
                    begin
                        phase_next     = P_IDLE;
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_FAIL;
                        out_point_next = '0;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            P_FIRST:
                            begin
                                vfirst_next    = req.f_value;
                                phase_next     = P_SECOND;
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_EVAL;
                                out_point_next = end_second_reg;
                            end
                            P_SECOND:
                            begin
                                out_valid_next = 1'b1;
                                phase_next     = P_IDLE;
                                out_point_next = '0;
                                if (sign32(vfirst_reg) != SGN_ZERO
                                    && sign32(vfirst_reg) == sign32(req.f_value))
                                begin
                                    out_kind_next = KIND_FAIL;
                                end
                                else if (vfirst_reg == '0)
                                begin
                                    out_kind_next  = KIND_ROOT;
                                    out_point_next = end_first_reg;
                                end
                                else if (req.f_value == '0)
                                begin
                                    out_kind_next  = KIND_ROOT;
                                    out_point_next = end_second_reg;
                                end
                                else
                                begin
                                    if (vfirst_reg[VALUE_W-1])
                                    begin
                                        low_next  = end_first_reg;
                                        high_next = end_second_reg;
                                    end
                                    else
                                    begin
                                        low_next  = end_second_reg;
                                        high_next = end_first_reg;
                                    end
                                    sum_w = wide_t'(end_first_reg) + wide_t'(end_second_reg);
                                    cur_next       = half33(sum_w);
                                    last_next      = umag_t'(mag33(wide_t'(end_second_reg)
                                                     - wide_t'(end_first_reg)));
                                    prev_next      = last_next;
                                    phase_next     = P_MID;
                                    out_kind_next  = KIND_EVAL;
                                    out_point_next = cur_next;
                                end
                            end
                            P_MID, P_ITER:
                            begin
                                if (phase_reg == P_ITER)
                                begin
                                    if (req.f_value[VALUE_W-1])
                                        low_next = cur_reg;
                                    else
                                        high_next = cur_reg;
                                    iter_next = iter_up;
                                end
                                if (iter_next >= max_iter_reg)
                                begin
                                    phase_next     = P_IDLE;
                                    out_valid_next = 1'b1;
                                    out_kind_next  = KIND_FAIL;
                                    out_point_next = '0;
                                end
                                else
                                begin
                                    f_next   = req.f_value;
                                    df_next  = req.df_value;
                                    ctl_next = C_LOAD;
                                end
                            end
                            default:
                            begin
                                phase_next = P_IDLE;
                            end
                        endcase
                    end
                end
            end
            C_LOAD:
            begin
                mpl_next[0] = mag33(dh);
                mpl_next[1] = mag33(dl);
                mpl_next[2] = {1'b0, prev_reg};
                for (int k = 0; k < LANES; k++)
                    acc_next[k] = '0;
                mcand_next = mag32(df_reg);
                rem_next   = '0;
                dvd_next   = {fmag, {FRAC_W{1'b0}}};
                cnt_next   = '0;
                ctl_next   = C_RUN;
            end
            C_RUN:
            begin
                // one multiplier bit per lane, one quotient bit per cycle
                if (cnt_reg < CNT_W'(MUL_STEPS))
                begin
                    for (int k = 0; k < LANES; k++)
                    begin
                        msum = {1'b0, acc_reg[k]}
                             + (mpl_reg[k][0] ? {1'b0, mcand_reg} : {(VALUE_W+1){1'b0}});
                        acc_next[k] = msum[VALUE_W:1];
                        mpl_next[k] = {msum[0], mpl_reg[k][VALUE_W:1]};
                    end
                end
                shifted = {rem_reg, dvd_reg[DIV_STEPS-1]};
                qbit    = (shifted >= {1'b0, mcand_reg});
                if (qbit)
                    shifted = shifted - {1'b0, mcand_reg};
                rem_next = shifted[VALUE_W-1:0];
                dvd_next = {dvd_reg[DIV_STEPS-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    ctl_next = C_DECIDE;
            end
            C_DECIDE:
            begin
                sb = sf;
                sa = (dh == '0 || sdf == SGN_ZERO) ? SGN_ZERO
                   : ((dh[VALUE_W] ^ df_reg[VALUE_W-1]) ? SGN_NEG : SGN_POS);
                ta = term_sgn(sa, sb, {acc_reg[0], mpl_reg[0]}, mb);
                sa = (dl == '0 || sdf == SGN_ZERO) ? SGN_ZERO
                   : ((dl[VALUE_W] ^ df_reg[VALUE_W-1]) ? SGN_NEG : SGN_POS);
                tb = term_sgn(sa, sb, {acc_reg[1], mpl_reg[1]}, mb);
                bisect_next = (ta != SGN_ZERO && ta == tb)
                            || (lhs > {acc_reg[2], mpl_reg[2]});
                half_next = half33(wide_t'(high_reg) - wide_t'(low_reg));
                if (sdf == SGN_ZERO)
                    q_next = '0;
                else if (f_reg[VALUE_W-1] ^ df_reg[VALUE_W-1])
                begin
                    if (qm > DIV_STEPS'(VALUE_MIN[VALUE_W-1:0]))
                        q_next = VALUE_MIN;
                    else
                        q_next = value_t'(~qm[VALUE_W-1:0] + 1'b1);
                end
                else
                begin
                    if (qm > DIV_STEPS'(VALUE_MAX))
                        q_next = VALUE_MAX;
                    else
                        q_next = value_t'(qm[VALUE_W-1:0]);
                end
                ctl_next = C_STEP;
            end
            C_STEP:
            begin
                prev_next = last_reg;
                if (bisect_reg)
                begin
                    step_mag = mag32(half_reg);
                    nxt      = sat33(wide_t'(low_reg) + wide_t'(half_reg));
                    root_hit = (nxt == low_reg);
                end
                else
                begin
                    step_mag = mag32(q_reg);
                    nxt      = sat33(wide_t'(cur_reg) - wide_t'(q_reg));
                    root_hit = (nxt == cur_reg);
                end
                last_next      = step_mag;
                cur_next       = nxt;
                out_valid_next = 1'b1;
                out_point_next = nxt;
                if (root_hit || step_mag < umag_t'(tol_reg))
                begin
                    out_kind_next = KIND_ROOT;
                    phase_next    = P_IDLE;
                end
                else
                begin
                    out_kind_next = KIND_EVAL;
                    phase_next    = P_ITER;
                end
                ctl_next = C_WAIT;
            end
            default:
            begin
                ctl_next = C_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= TOL_W'(1);
            max_iter_reg <= ITER_W'(50);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOLERANCE: tol_reg      <= cfg_data;
                CFG_MAX_ITER:  max_iter_reg <= cfg_data[ITER_W-1:0];
                default:       tol_reg      <= tol_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= P_IDLE;
            ctl_reg        <= C_WAIT;
            end_first_reg  <= '0;
            end_second_reg <= '0;
            vfirst_reg     <= '0;
            low_reg        <= '0;
            high_reg       <= '0;
            cur_reg        <= '0;
            last_reg       <= '0;
            prev_reg       <= '0;
            iter_reg       <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            ctl_reg        <= ctl_next;
            end_first_reg  <= end_first_next;
            end_second_reg <= end_second_next;
            vfirst_reg     <= vfirst_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            cur_reg        <= cur_next;
            last_reg       <= last_next;
            prev_reg       <= prev_next;
            iter_reg       <= iter_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg         <= f_next;
        df_reg        <= df_next;
        acc_reg       <= acc_next;
        mpl_reg       <= mpl_next;
        mcand_reg     <= mcand_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        bisect_reg    <= bisect_next;
        half_reg      <= half_next;
        q_reg         <= q_next;
        out_kind_reg  <= out_kind_next;
        out_point_reg <= out_point_next;
    end

    // no result may be pending while a step is being computed
    a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg != C_WAIT) |-> !out_valid_reg)
        else $error("result pending during step computation");

    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == C_STEP) |=> (out_valid_reg && ctl_reg == C_WAIT))
        else $error("step finished without a result");

    a_start_asks_first: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req.opcode == OP_START) |=>
            (out_valid_reg && out_kind_reg == KIND_EVAL && phase_reg == P_FIRST
             && out_point_reg == $past(req.bracket_first)))
        else $error("start request did not ask for the first end");

    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == C_RUN) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("serial unit counter overran");

endmodule
